// ----- sv/ffba_pkg.sv -----
package ffba_pkg;

	localparam int MAX_BLOCKS   = 64;
	localparam int HEADER_BYTES = 16;
	localparam int ADDR_W       = 20;
	localparam int SIZE_W       = 21;
	localparam int IDX_W        = $clog2(MAX_BLOCKS);
	localparam int CNT_W        = IDX_W + 1;

	localparam logic [1:0] OP_ALLOC   = 2'd0;
	localparam logic [1:0] OP_RELEASE = 2'd1;
	localparam logic [1:0] OP_RESIZE  = 2'd2;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NOSPACE = 2'd1;
	localparam logic [1:0] ST_NULL    = 2'd2;
	localparam logic [1:0] ST_UNKNOWN = 2'd3;

	// Work classes decided by the front end.
	localparam logic [1:0] K_IMM   = 2'd0;
	localparam logic [1:0] K_ALLOC = 2'd1;
	localparam logic [1:0] K_FIND  = 2'd2;

	typedef struct packed {
		logic [1:0]        opcode;
		logic [ADDR_W-1:0] block_address;
		logic [SIZE_W-1:0] request_size;
	} req_t;

	typedef struct packed {
		logic [ADDR_W-1:0] result_address;
		logic [1:0]        status;
		logic              copy_needed;
		logic [SIZE_W-1:0] copy_bytes;
	} rsp_t;

	typedef struct packed {
		logic [1:0]        kind;
		logic [1:0]        status;
		logic [1:0]        opcode;
		logic [ADDR_W-1:0] addr;
		logic [SIZE_W-1:0] size;
	} qent_t;

endpackage

// ----- sv/ffba_front.sv -----
module ffba_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	input  ffba_pkg::req_t  req,
	output logic            q_valid,
	output ffba_pkg::qent_t q_ent,
	input  logic            q_pop
);

	ffba_pkg::qent_t fifo_q [2];
	ffba_pkg::qent_t cls;
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [1:0]      fill_q;
	logic            push;

	// Requests that need no table access are answered straight from the queue.
	always_comb begin
		cls.opcode = req.opcode;
		cls.addr   = req.block_address;
		cls.size   = req.request_size;
		cls.status = ffba_pkg::ST_OK;
		cls.kind   = ffba_pkg::K_IMM;
		unique case (req.opcode)
			ffba_pkg::OP_ALLOC: begin
				if (req.request_size == '0) begin
					cls.status = ffba_pkg::ST_NULL;
				end else begin
					cls.kind = ffba_pkg::K_ALLOC;
				end
			end
			ffba_pkg::OP_RELEASE: begin
				if (req.block_address == '0) begin
					cls.status = ffba_pkg::ST_NULL;
				end else begin
					cls.kind = ffba_pkg::K_FIND;
				end
			end
			ffba_pkg::OP_RESIZE: begin
				if (req.block_address == '0 || req.request_size == '0) begin
					cls.status = ffba_pkg::ST_NULL;
				end else begin
					cls.kind = ffba_pkg::K_FIND;
				end
			end
			default: begin
				cls.kind = ffba_pkg::K_IMM;
			end
		endcase
	end

	assign req_ready = (fill_q != 2'd2);
	assign push      = req_valid && req_ready;
	assign q_valid   = (fill_q != 2'd0);
	assign q_ent     = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			fill_q <= fill_q + 2'(push) - 2'(q_pop);
		end
	end

endmodule

// ----- sv/ffba_back.sv -----
module ffba_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            q_valid,
	input  ffba_pkg::qent_t                 q_ent,
	output logic                            q_pop,
	input  logic [ffba_pkg::SIZE_W-1:0]     heap_limit,
	output logic                            rsp_valid,
	input  logic                            rsp_ready,
	output ffba_pkg::rsp_t                  rsp
);

	localparam int AW = ffba_pkg::ADDR_W;
	localparam int SW = ffba_pkg::SIZE_W;
	localparam int IW = ffba_pkg::IDX_W;
	localparam int CW = ffba_pkg::CNT_W;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_FIND = 3'd1;
	localparam logic [2:0] S_FIT  = 3'd2;
	localparam logic [2:0] S_GROW = 3'd3;
	localparam logic [2:0] S_REL  = 3'd4;
	localparam logic [2:0] S_DONE = 3'd5;

	typedef struct packed {
		logic          free;
		logic [SW-1:0] size;
		logic [AW-1:0] start;
	} row_t;

	row_t mem [ffba_pkg::MAX_BLOCKS];

	logic [2:0]      st_q;
	ffba_pkg::qent_t ent_q;
	logic [CW-1:0]   rd_idx_q;
	logic            cmp_v_s1;
	logic [IW-1:0]   cmp_idx_s1;
	row_t            row_s1;
	logic [IW-1:0]   f_idx_q;
	logic [AW-1:0]   f_start_q;
	logic [SW-1:0]   f_size_q;
	logic [CW-1:0]   cnt_q;
	logic [SW-1:0]   brk_q;
	ffba_pkg::rsp_t  res_q;
	ffba_pkg::rsp_t  rsp_q;
	logic            rsp_valid_q;

	logic            hit;
	logic            last;
	logic            fit;
	logic            leaving;
	logic            walking;
	logic            rewalk;
	logic            full;
	logic [SW:0]     nb;
	logic [SW:0]     lim;
	logic            grow_ok;
	logic            rel_last;
	logic            we;
	logic [IW-1:0]   wa;
	row_t            wd;
	logic            load_out;

	assign hit  = cmp_v_s1
		&& ({1'b0, row_s1.start} + (AW+1)'(ffba_pkg::HEADER_BYTES) == {1'b0, ent_q.addr});
	assign last = cmp_v_s1 && ({1'b0, cmp_idx_s1} + CW'(1) == cnt_q);
	assign fit  = cmp_v_s1 && row_s1.free && (row_s1.size >= ent_q.size);
	assign walking = (st_q == S_FIND) || (st_q == S_FIT);
	assign leaving = ((st_q == S_FIND) && (hit || last)) || ((st_q == S_FIT) && (fit || last));
	// A resize that outgrows its block starts a second walk for a free fit.
	assign rewalk = (st_q == S_FIND) && hit && (ent_q.opcode != ffba_pkg::OP_RELEASE)
		&& !(row_s1.size >= ent_q.size);
	assign full = (cnt_q == CW'(ffba_pkg::MAX_BLOCKS));
	assign nb   = {1'b0, brk_q} + (SW+1)'(ffba_pkg::HEADER_BYTES) + {1'b0, ent_q.size};
	assign lim  = ({1'b0, heap_limit} > (SW+1)'(1 << AW)) ? (SW+1)'(1 << AW)
		: {1'b0, heap_limit};
	assign grow_ok  = !full && (nb <= lim);
	assign rel_last = ({1'b0, f_idx_q} + CW'(1) == cnt_q);
	assign q_pop    = (st_q == S_IDLE) && q_valid;
	assign load_out = (st_q == S_DONE) && (!rsp_valid_q || rsp_ready);

	always_comb begin
		we = 1'b0;
		wa = cmp_idx_s1;
		wd = row_s1;
		unique case (st_q)
			S_FIT: begin
				if (fit) begin
					we      = 1'b1;
					wd.free = 1'b0;
				end
			end
			S_GROW: begin
				we = grow_ok;
				wa = cnt_q[IW-1:0];
				wd = '{free: 1'b0, size: ent_q.size, start: brk_q[AW-1:0]};
			end
			S_REL: begin
				we = !rel_last;
				wa = f_idx_q;
				wd = '{free: 1'b1, size: f_size_q, start: f_start_q};
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		row_s1     <= mem[rd_idx_q[IW-1:0]];
		cmp_idx_s1 <= rd_idx_q[IW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_IDLE;
			cmp_v_s1    <= 1'b0;
			rd_idx_q    <= '0;
			cnt_q       <= '0;
			brk_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			cmp_v_s1 <= walking && !leaving && (rd_idx_q < cnt_q);
			if ((st_q == S_IDLE) || rewalk) begin
				rd_idx_q <= '0;
			end else if (walking) begin
				rd_idx_q <= rd_idx_q + CW'(1);
			end
			if (load_out) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (st_q)
				S_IDLE: begin
					if (q_valid) begin
						unique case (q_ent.kind)
							ffba_pkg::K_ALLOC: begin
								st_q <= (cnt_q == '0) ? S_GROW : S_FIT;
							end
							ffba_pkg::K_FIND: begin
								st_q <= (cnt_q == '0) ? S_DONE : S_FIND;
							end
							default: begin
								st_q <= S_DONE;
							end
						endcase
					end
				end
				S_FIND: begin
					if (hit) begin
						if (ent_q.opcode == ffba_pkg::OP_RELEASE) begin
							st_q <= S_REL;
						end else if (row_s1.size >= ent_q.size) begin
							st_q <= S_DONE;
						end else begin
							st_q <= S_FIT;
						end
					end else if (last) begin
						st_q <= S_DONE;
					end
				end
				S_FIT: begin
					if (fit) begin
						st_q <= (ent_q.opcode == ffba_pkg::OP_RESIZE) ? S_REL : S_DONE;
					end else if (last) begin
						st_q <= S_GROW;
					end
				end
				S_GROW: begin
					if (grow_ok) begin
						cnt_q <= cnt_q + CW'(1);
						brk_q <= nb[SW-1:0];
						st_q  <= (ent_q.opcode == ffba_pkg::OP_RESIZE) ? S_REL : S_DONE;
					end else begin
						st_q <= S_DONE;
					end
				end
				S_REL: begin
					if (rel_last) begin
						brk_q <= {1'b0, f_start_q};
						cnt_q <= cnt_q - CW'(1);
					end
					st_q <= S_DONE;
				end
				S_DONE: begin
					if (load_out) begin
						st_q <= S_IDLE;
					end
				end
				default: begin
					st_q <= S_IDLE;
				end
			endcase
		end
	end

	// Item payload and result assembly.
	always_ff @(posedge clk) begin
		if (load_out) begin
			rsp_q <= res_q;
		end
		unique case (st_q)
			S_IDLE: begin
				ent_q                <= q_ent;
				res_q.result_address <= '0;
				res_q.copy_needed    <= 1'b0;
				res_q.copy_bytes     <= '0;
				if (q_ent.kind == ffba_pkg::K_IMM) begin
					res_q.status <= q_ent.status;
				end else if (q_ent.kind == ffba_pkg::K_FIND && cnt_q == '0) begin
					res_q.status <= ffba_pkg::ST_UNKNOWN;
				end else begin
					res_q.status <= ffba_pkg::ST_OK;
				end
			end
			S_FIND: begin
				if (hit) begin
					f_idx_q   <= cmp_idx_s1;
					f_start_q <= row_s1.start;
					f_size_q  <= row_s1.size;
					if (ent_q.opcode == ffba_pkg::OP_RESIZE && row_s1.size >= ent_q.size) begin
						res_q.result_address <= ent_q.addr;
					end
				end else if (last) begin
					res_q.status <= ffba_pkg::ST_UNKNOWN;
				end
			end
			S_FIT: begin
				if (fit) begin
					res_q.result_address <= row_s1.start + AW'(ffba_pkg::HEADER_BYTES);
				end
			end
			S_GROW: begin
				if (grow_ok) begin
					res_q.result_address <= brk_q[AW-1:0] + AW'(ffba_pkg::HEADER_BYTES);
				end else begin
					res_q.status <= ffba_pkg::ST_NOSPACE;
				end
			end
			S_REL: begin
				if (ent_q.opcode == ffba_pkg::OP_RESIZE) begin
					res_q.copy_needed <= 1'b1;
					res_q.copy_bytes  <= f_size_q;
				end
			end
			default: begin
				res_q <= res_q;
			end
		endcase
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ----- sv/first_fit_block_allocator.sv -----
// A request is handled in the back end either without the table (null, zero or undefined
// requests) or with walks of the table, two for a resize that moves; each walk
// reads one table entry per cycle from the block table.
// The back end takes one request at a time, so the walk sets the request rate.
// Reset: block count and heap break clear, heap_limit returns to 2^20; table contents
// are not cleared, since only entries below the count are ever read.
module first_fit_block_allocator (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_ready,
	input  ffba_pkg::req_t              req,
	output logic                        rsp_valid,
	input  logic                        rsp_ready,
	output ffba_pkg::rsp_t              rsp,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [ffba_pkg::SIZE_W-1:0] cfg_data
);

	// The heap limit is taken on any cfg transfer; the user is to write it only while
	// idle, which the block itself does not enforce; the back end reads it directly.
	logic [ffba_pkg::SIZE_W-1:0] heap_limit_q;

	// Queue between the classifier and the table sequencer.
	logic            q_valid;
	logic            q_pop;
	ffba_pkg::qent_t q_ent;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heap_limit_q <= ffba_pkg::SIZE_W'(1 << ffba_pkg::ADDR_W);
		end else if (cfg_valid) begin
			heap_limit_q <= cfg_data;
		end
	end

	// The front end classifies each request transfer and queues it, so a new
	// request can be taken while the back end is still walking the table.
	ffba_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.q_valid   (q_valid),
		.q_ent     (q_ent),
		.q_pop     (q_pop)
	);

	// The back end owns the block table, the count and the break, and holds
	// the finished result in an output register until its transfer.
	ffba_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.q_ent      (q_ent),
		.q_pop      (q_pop),
		.heap_limit (heap_limit_q),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.rsp        (rsp)
	);

`ifndef SYNTH
	// The sequencer never takes an item from an empty queue.
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("queue popped while empty");

	// A copy request only comes with a successful, granted resize.
	a_copy_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.copy_needed |->
			rsp.status == ffba_pkg::ST_OK && rsp.result_address != '0)
		else $error("copy requested without a grant");

	// Any failure grants nothing.
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != ffba_pkg::ST_OK |->
			rsp.result_address == '0 && !rsp.copy_needed && rsp.copy_bytes == '0)
		else $error("failed request carries a grant");
`endif

endmodule

// ----- verif/first_fit_block_allocator_tb.sv -----
`timescale 1ns / 100ps

// Checks the first-fit block allocator against a behavioral copy of its block
// table. Every accepted request updates the copy and queues the response that
// the block must give; every accepted response is compared with the oldest one.
class alloc_scoreboard;
	logic [19:0] blk_start[$];
	logic [20:0] blk_size[$];
	bit          blk_free[$];
	logic [20:0] brk;
	logic [20:0] limit;
	ffba_pkg::rsp_t pending[$];
	int unsigned errors;

	function new();
		brk = 0;
		limit = 21'h100000;
		errors = 0;
	endfunction

	function int lookup(logic [19:0] a);
		foreach (blk_start[i])
			if (21'(blk_start[i]) + ffba_pkg::HEADER_BYTES == 21'(a))
				return i;
		return -1;
	endfunction

	// First fit: reuse a free block without splitting, else grow the break.
	function logic [19:0] grab(logic [20:0] sz);
		logic [21:0] nb;
		logic [21:0] lim;
		foreach (blk_start[i])
			if (blk_free[i] && blk_size[i] >= sz) begin
				blk_free[i] = 0;
				return 20'(blk_start[i] + ffba_pkg::HEADER_BYTES);
			end
		if (blk_start.size() >= ffba_pkg::MAX_BLOCKS)
			return 0;
		lim = (limit > 21'h100000) ? 22'h100000 : 22'(limit);
		nb = 22'(brk) + 22'(ffba_pkg::HEADER_BYTES) + 22'(sz);
		if (nb > lim)
			return 0;
		blk_start.push_back(brk[19:0]);
		blk_size.push_back(sz);
		blk_free.push_back(0);
		brk = nb[20:0];
		return 20'(blk_start[$] + ffba_pkg::HEADER_BYTES);
	endfunction

	function void drop(int idx);
		if (idx == blk_start.size() - 1) begin
			brk = 21'(blk_start[idx]);
			blk_start.pop_back();
			blk_size.pop_back();
			blk_free.pop_back();
		end else begin
			blk_free[idx] = 1;
		end
	endfunction

	function void note_request(ffba_pkg::req_t r);
		ffba_pkg::rsp_t e;
		int idx;
		logic [20:0] old;
		e = '0;
		case (r.opcode)
			ffba_pkg::OP_ALLOC: begin
				if (r.request_size == 0) e.status = ffba_pkg::ST_NULL;
				else begin
					e.result_address = grab(r.request_size);
					if (e.result_address == 0) e.status = ffba_pkg::ST_NOSPACE;
				end
			end
			ffba_pkg::OP_RELEASE: begin
				if (r.block_address == 0) e.status = ffba_pkg::ST_NULL;
				else begin
					idx = lookup(r.block_address);
					if (idx < 0) e.status = ffba_pkg::ST_UNKNOWN;
					else drop(idx);
				end
			end
			ffba_pkg::OP_RESIZE: begin
				if (r.block_address == 0 || r.request_size == 0)
					e.status = ffba_pkg::ST_NULL;
				else begin
					idx = lookup(r.block_address);
					if (idx < 0) e.status = ffba_pkg::ST_UNKNOWN;
					else if (blk_size[idx] >= r.request_size)
						e.result_address = r.block_address;
					else begin
						old = blk_size[idx];
						e.result_address = grab(r.request_size);
						if (e.result_address == 0) e.status = ffba_pkg::ST_NOSPACE;
						else begin
							e.copy_needed = 1;
							e.copy_bytes = old;
							drop(idx);
						end
					end
				end
			end
			default: ;
		endcase
		pending.push_back(e);
	endfunction

	task complain(string what);
		$display("MISMATCH at %0t: %s", $realtime, what);
		errors++;
	endtask

	task check_response(ffba_pkg::rsp_t got);
		ffba_pkg::rsp_t e;
		if (pending.size() == 0) begin
			complain("response with nothing outstanding");
			return;
		end
		e = pending.pop_front();
		if (got.result_address !== e.result_address)
			complain($sformatf("result_address %h, wanted %h", got.result_address,
				e.result_address));
		if (got.status !== e.status)
			complain($sformatf("status %0d, wanted %0d", got.status, e.status));
		if (got.copy_needed !== e.copy_needed)
			complain($sformatf("copy_needed %b, wanted %b", got.copy_needed,
				e.copy_needed));
		if (got.copy_bytes !== e.copy_bytes)
			complain($sformatf("copy_bytes %h, wanted %h", got.copy_bytes, e.copy_bytes));
	endtask
endclass

module first_fit_block_allocator_tb;

	// Opcode value that the block leaves undefined.
	localparam logic [1:0] OP_UNUSED = 2'd3;

	logic           clk = 0;
	logic           arst_n = 0;
	logic           req_valid = 0;
	logic           req_ready;
	ffba_pkg::req_t req = '0;
	logic           rsp_valid;
	logic           rsp_ready = 0;
	ffba_pkg::rsp_t rsp;
	logic           cfg_valid = 0;
	logic           cfg_ready;
	logic [20:0]    cfg_data = '0;

	alloc_scoreboard board = new();
	int unsigned cycle_count = 0;
	bit          stim_done = 0;

	always begin
		#2 clk = 1;
		#2 clk = 0;
	end

	first_fit_block_allocator u_top (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .req(req),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	// The watchdog covers the slowest legal run: each request walks the table
	// twice plus idle gaps on both sides, taken many times over.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 1000000) begin
			$display("Verification failed");
			$finish;
		end
	end

	// Response side: random stalls, check on every completed transfer.
	initial begin
		int w;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			w = (cycle_count % 3000 < 1000) ? 0 : $urandom_range(0, 3);
			if (w != 0) begin
				rsp_ready <= 0;
				repeat (w) @(negedge clk);
			end
			rsp_ready <= 1;
			do @(posedge clk); while (!rsp_valid);
			board.check_response(rsp);
			@(negedge clk);
		end
	end

	task automatic wait_drained();
		while (board.pending.size() != 0) @(negedge clk);
		// Room for any request still in flight in the back end.
		repeat (150) @(negedge clk);
	endtask

	task automatic write_limit(logic [20:0] v);
		wait_drained();
		cfg_valid <= 1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		board.limit = v;
		@(negedge clk);
		cfg_valid <= 0;
	endtask

	// Sends one request. Valid stays up when the next request follows at once.
	task automatic send(logic [1:0] op, logic [19:0] a, logic [20:0] sz);
		int w;
		w = (cycle_count % 3000 < 1000) ? 0 : $urandom_range(0, 3);
		if (w != 0) begin
			req_valid <= 0;
			repeat (w) @(negedge clk);
		end
		req_valid <= 1;
		req <= '{opcode: op, block_address: a, request_size: sz};
		do @(posedge clk); while (!req_ready);
		board.note_request('{opcode: op, block_address: a, request_size: sz});
		@(negedge clk);
	endtask

	task automatic idle_req();
		req_valid <= 0;
	endtask

	// Picks a data address of a live block most of the time, otherwise noise.
	function automatic logic [19:0] pick_addr();
		int n;
		n = board.blk_start.size();
		if (n != 0 && $urandom_range(0, 9) < 8)
			return 20'(board.blk_start[$urandom_range(0, n - 1)] + ffba_pkg::HEADER_BYTES);
		if ($urandom_range(0, 1)) return 20'($urandom);
		return 20'h00010 + 20'($urandom_range(0, 255));
	endfunction

	// Small sizes mostly so that blocks are reused; a few large ones hit the limit.
	function automatic logic [20:0] pick_size();
		int r;
		r = $urandom_range(0, 99);
		if (r < 3) return 0;
		if (r < 8) return 21'($urandom);
		if (r < 10) return 21'h100000;
		return 21'($urandom_range(1, 300));
	endfunction

	initial begin
		int i;
		int op_r;
		logic [20:0] lims[5];
		repeat (11) @(negedge clk);
		arst_n <= 1;
		@(negedge clk);

		// Directed: each operation, null and zero cases, unknown address,
		// undefined opcode, free-of-free, resize in place and with a move.
		send(ffba_pkg::OP_ALLOC, 0, 0);
		send(ffba_pkg::OP_RELEASE, 0, 5);
		send(ffba_pkg::OP_RESIZE, 0, 5);
		send(ffba_pkg::OP_RESIZE, 20'h10, 0);
		send(ffba_pkg::OP_RELEASE, 20'hFFFFF, 0);
		send(ffba_pkg::OP_ALLOC, 20'hFFFFF, 100);
		send(ffba_pkg::OP_ALLOC, 0, 50);
		send(ffba_pkg::OP_ALLOC, 0, 21'h1FFFFF);
		send(ffba_pkg::OP_ALLOC, 0, 21'h100000);
		send(OP_UNUSED, 20'hFFFFF, 21'h1FFFFF);
		send(ffba_pkg::OP_RELEASE, 20'h10, 0);
		send(ffba_pkg::OP_RELEASE, 20'h10, 0);
		send(ffba_pkg::OP_ALLOC, 0, 80);
		send(ffba_pkg::OP_RESIZE, 20'h10, 40);
		send(ffba_pkg::OP_RESIZE, 20'h10, 200);
		send(ffba_pkg::OP_RESIZE, 20'h84, 21'h100000);
		send(ffba_pkg::OP_RESIZE, 20'h12345, 3);
		send(ffba_pkg::OP_ALLOC, 0, 1);
		idle_req();
		write_limit(21'h1FFFFF);
		send(ffba_pkg::OP_ALLOC, 0, 21'h0FFF00);
		send(ffba_pkg::OP_ALLOC, 0, 21'h100000);
		idle_req();

		lims = '{21'h100000, 21'h0, 21'h1FFFFF, 21'h800, 21'h4000};
		for (i = 0; i < 1800; i++) begin
			if (i % 360 == 0) begin
				idle_req();
				write_limit(lims[i / 360]);
				// Empty the table now and then so the break comes back down.
				while (board.blk_start.size() != 0 && lims[i / 360] == 21'h800)
					send(ffba_pkg::OP_RELEASE,
						20'(board.blk_start[$] + ffba_pkg::HEADER_BYTES), 0);
			end
			if (i == 900) begin
				idle_req();
				wait_drained();
			end
			op_r = $urandom_range(0, 99);
			if (op_r < 42) send(ffba_pkg::OP_ALLOC, 20'($urandom), pick_size());
			else if (op_r < 74) send(ffba_pkg::OP_RELEASE, pick_addr(), 21'($urandom));
			else if (op_r < 97) send(ffba_pkg::OP_RESIZE, pick_addr(), pick_size());
			else send(OP_UNUSED, 20'($urandom), 21'($urandom));
		end
		idle_req();
		stim_done = 1;
	end

	initial begin
		wait (stim_done);
		while (board.pending.size() != 0) @(negedge clk);
		repeat (200) @(negedge clk);
		if (board.errors == 0 && board.pending.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule
